// File: design/isbnv_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, character codes and modulo-11 helper for the ISBN-10 validator.
package isbnv_pkg;

	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_X      = 8'd88;
	localparam logic [7:0] CH_HYPHEN = 8'd45;

	localparam logic [3:0] MODULUS     = 4'd11;
	localparam logic [3:0] WEIGHT_INIT = 4'd10;
	localparam logic [3:0] X_VALUE     = 4'd10;

	localparam logic [1:0] REG_MAX_GROUP     = 2'd0;
	localparam logic [1:0] REG_MAX_PUBLISHER = 2'd1;
	localparam logic [1:0] REG_MAX_TITLE     = 2'd2;

	localparam logic [2:0] MAX_GROUP_RST     = 3'd5;
	localparam logic [2:0] MAX_PUBLISHER_RST = 3'd7;
	localparam logic [2:0] MAX_TITLE_RST     = 3'd6;

	typedef enum logic [2:0] {
		PH_COUNTRY   = 3'd0,
		PH_PUBLISHER = 3'd1,
		PH_TITLE     = 3'd2,
		PH_CHECK     = 3'd3,
		PH_TERM      = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] group_count;
		logic [3:0] weight;
		logic [3:0] sum_mod;
		logic [3:0] check_value;
		logic       failed;
	} parse_state_t;

	typedef struct packed {
		logic [2:0] max_group_len;
		logic [2:0] max_publisher_len;
		logic [2:0] max_title_len;
	} limits_t;

	typedef struct packed {
		logic valid;
		logic isbn_ok;
		logic syntax_ok;
	} verdict_t;

	localparam parse_state_t STATE_RST = '{
		phase:       PH_COUNTRY,
		group_count: 3'd0,
		weight:      WEIGHT_INIT,
		sum_mod:     4'd0,
		check_value: 4'd0,
		failed:      1'b0
	};

	// Residue modulo 11 of a value up to 127: reciprocal multiply, one correction.
	function automatic logic [3:0] mod11(input logic [6:0] v);
		logic [13:0] prod;
		logic [3:0]  q;
		logic [7:0]  qm;
		logic [6:0]  r;
		begin
			prod = 14'(v) * 14'd93;
			q    = prod[13:10];
			qm   = 8'(q) * 8'(MODULUS);
			r    = v - qm[6:0];
			if (r >= 7'(MODULUS)) begin
				r = r - 7'(MODULUS);
			end
			mod11 = r[3:0];
		end
	endfunction

endpackage

// File: design/isbnv_step.sv
`timescale 1ns / 1ps
// Parser step: next parse state and verdict for one character.
module isbnv_step (
	input  isbnv_pkg::parse_state_t state,
	input  logic [7:0]              char_in,
	input  isbnv_pkg::limits_t      limits,
	output isbnv_pkg::parse_state_t state_next,
	output isbnv_pkg::verdict_t     verdict
);

	logic       is_digit;
	logic [7:0] digit_full;
	logic [3:0] digit;
	logic [2:0] limit;
	logic [7:0] prod;
	logic [7:0] acc;
	logic [3:0] expect_val;
	logic       syn;

	assign is_digit   = (char_in >= isbnv_pkg::CH_ZERO) && (char_in <= isbnv_pkg::CH_NINE);
	assign digit_full = char_in - isbnv_pkg::CH_ZERO;
	assign digit      = digit_full[3:0];
	assign prod       = 8'(state.weight) * 8'(digit);
	assign acc        = prod + 8'(state.sum_mod);
	assign expect_val = (state.sum_mod == 4'd0) ? 4'd0 : (isbnv_pkg::MODULUS - state.sum_mod);
	assign syn        = !state.failed && (state.phase == isbnv_pkg::PH_TERM);

	always_comb begin
		unique case (state.phase)
			isbnv_pkg::PH_COUNTRY:   limit = limits.max_group_len;
			isbnv_pkg::PH_PUBLISHER: limit = limits.max_publisher_len;
			default:                 limit = limits.max_title_len;
		endcase
	end

	always_comb begin
		state_next = state;
		verdict    = '{valid: 1'b0, isbn_ok: 1'b0, syntax_ok: 1'b0};
		if (char_in == isbnv_pkg::CH_NUL) begin
			verdict.valid     = 1'b1;
			verdict.syntax_ok = syn;
			verdict.isbn_ok   = syn && (expect_val == state.check_value);
			state_next        = isbnv_pkg::STATE_RST;
		end else if (!state.failed) begin
			unique case (state.phase)
				isbnv_pkg::PH_COUNTRY, isbnv_pkg::PH_PUBLISHER, isbnv_pkg::PH_TITLE: begin
					if (char_in == isbnv_pkg::CH_HYPHEN) begin
						if (state.group_count == 3'd0) begin
							state_next.failed = 1'b1;
						end else begin
							state_next.group_count = 3'd0;
							unique case (state.phase)
								isbnv_pkg::PH_COUNTRY:   state_next.phase = isbnv_pkg::PH_PUBLISHER;
								isbnv_pkg::PH_PUBLISHER: state_next.phase = isbnv_pkg::PH_TITLE;
								default:                 state_next.phase = isbnv_pkg::PH_CHECK;
							endcase
						end
					end else if ((state.group_count >= limit) || !is_digit) begin
						state_next.failed = 1'b1;
					end else begin
						state_next.group_count = state.group_count + 3'd1;
						if (state.weight > 4'd1) begin
							state_next.sum_mod = isbnv_pkg::mod11(acc[6:0]);
							state_next.weight  = state.weight - 4'd1;
						end
					end
				end
				isbnv_pkg::PH_CHECK: begin
					if (is_digit) begin
						state_next.check_value = digit;
						state_next.phase       = isbnv_pkg::PH_TERM;
					end else if (char_in == isbnv_pkg::CH_X) begin
						state_next.check_value = isbnv_pkg::X_VALUE;
						state_next.phase       = isbnv_pkg::PH_TERM;
					end else begin
						state_next.failed = 1'b1;
					end
				end
				default: begin
					state_next.failed = 1'b1;
				end
			endcase
		end
	end

endmodule

// File: design/isbn10_hyphenated_validator.sv
`timescale 1ns / 1ps
// Top level: hyphenated ISBN-10 validator with input register and verdict register.
//
// Characters arrive on the char channel (char_valid, char_stall, char_code), one per
// transfer; a zero byte ends the string. Each string yields exactly one verdict on
// the verdict channel (verdict_valid, verdict_stall, isbn_ok, syntax_ok), issued for
// the terminator; other characters produce nothing.
// Throughput: one character per cycle while char_stall is low; the parser step and
// modulo-11 accumulator between input register and parse state are combinational.
// A terminator accepted into the input register passes the parser step, and its verdict
// is captured in the verdict register that drives verdict_valid, isbn_ok and syntax_ok.
// The verdict register lets characters keep flowing while a verdict waits. Only a
// terminator held in the input register while the previous verdict is still stalled
// blocks the input; char_stall then rises until the waiting verdict transfers.
// The user writes group limits through cfg_we, cfg_index and cfg_data only while the
// block is idle (the block itself does not enforce this): index 0 country group, 1
// publisher group, 2 title group. Reset (arst_n low) empties both registers, returns
// the parser to the start of a string and loads the group limits with 5, 7 and 6.
module isbn10_hyphenated_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic       isbn_ok,
	output logic       syntax_ok,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data
);

	isbnv_pkg::limits_t      limits_q;
	isbnv_pkg::parse_state_t state_q;
	isbnv_pkg::parse_state_t state_next;
	isbnv_pkg::verdict_t     verdict_c;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       verdict_valid_q;
	logic       isbn_ok_q;
	logic       syntax_ok_q;
	logic       advance;
	logic       accept;
	logic       step_fire;

	isbnv_step u_step (
		.state      (state_q),
		.char_in    (char_s1),
		.limits     (limits_q),
		.state_next (state_next),
		.verdict    (verdict_c)
	);

	assign advance    = !verdict_c.valid || !verdict_valid_q || !verdict_stall;
	assign step_fire  = valid_s1 && advance;
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= '{max_group_len:     isbnv_pkg::MAX_GROUP_RST,
			              max_publisher_len: isbnv_pkg::MAX_PUBLISHER_RST,
			              max_title_len:     isbnv_pkg::MAX_TITLE_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				isbnv_pkg::REG_MAX_GROUP:     limits_q.max_group_len     <= cfg_data;
				isbnv_pkg::REG_MAX_PUBLISHER: limits_q.max_publisher_len <= cfg_data;
				isbnv_pkg::REG_MAX_TITLE:     limits_q.max_title_len     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isbnv_pkg::STATE_RST;
		end else if (step_fire) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (step_fire && verdict_c.valid) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && verdict_c.valid) begin
			isbn_ok_q   <= verdict_c.isbn_ok;
			syntax_ok_q <= verdict_c.syntax_ok;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign isbn_ok       = isbn_ok_q;
	assign syntax_ok     = syntax_ok_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (verdict_valid_q && verdict_stall && valid_s1))
		else $error("input stalled without a waiting verdict");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && verdict_c.valid) |=>
			(state_q.phase == isbnv_pkg::PH_COUNTRY && state_q.weight == isbnv_pkg::WEIGHT_INIT
			 && !state_q.failed && verdict_valid_q))
		else $error("parser did not restart after verdict");

	a_ok_needs_syntax: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_valid_q && isbn_ok_q) |-> syntax_ok_q)
		else $error("isbn_ok without syntax_ok");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.sum_mod < isbnv_pkg::MODULUS) && (state_q.weight >= 4'd1)
		&& (state_q.weight <= isbnv_pkg::WEIGHT_INIT))
		else $error("accumulator out of range");

endmodule
